// ===== hw/rtl/mba_pkg.sv =====
// ----------------------------------------------------------------------------
// mba_pkg
// Shared types, constants and the binary32 round-and-pack helper for the
// single-precision matrix multiply-add block.
// ----------------------------------------------------------------------------
package mba_pkg;

   // largest matrix side supported
   localparam int MBA_MAX_DIM = 8;

   // depth of the queue between front and back (power of two)
   localparam int MBA_QUEUE_DEPTH = 4;

   // canonical quiet nan
   localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

   // item kinds
   typedef enum logic [1:0] {
      KIND_A     = 2'd0,
      KIND_B     = 2'd1,
      KIND_C     = 2'd2,
      KIND_START = 2'd3
   } kind_type;

   // register indexes
   typedef enum logic [1:0] {
      CSR_ROW_COUNT   = 2'd0,
      CSR_COL_COUNT   = 2'd1,
      CSR_INNER_COUNT = 2'd2,
      CSR_BIAS_ENABLE = 2'd3
   } csr_index_type;

   // dimensions already clamped to 1..max
   typedef struct packed {
      logic [3:0] rows;
      logic [3:0] cols;
      logic [3:0] inner;
      logic       bias;
   } cfg_type;

   // round to nearest even and pack; man_in[26] is the leading one,
   // value = man_in / 2^26 * 2^(exp_in - 127), man_in[0] is sticky
   function automatic logic [31:0] fp_round_pack(input logic              sgn,
                                                 input logic signed [11:0] exp_in,
                                                 input logic [26:0]        man_in);
      logic [26:0]        man_sh;
      logic [26:0]        lost_mask;
      logic signed [11:0] shamt_full;
      logic [4:0]         shamt;
      logic [9:0]         exp_n;
      logic               inc;
      logic [24:0]        sum;
      logic [9:0]         exp_out;
      logic [31:0]        res;
      man_sh     = man_in;
      lost_mask  = '0;
      shamt_full = '0;
      shamt      = '0;
      exp_n      = '0;
      // denormalize when the exponent falls below the normal range
      if (exp_in >= 12'sd1) begin
         exp_n = exp_in[9:0];
      end else begin
         shamt_full = 12'sd1 - exp_in;
         if (shamt_full >= 12'sd27) begin
            man_sh = {26'd0, |man_in};
         end else begin
            shamt     = shamt_full[4:0];
            lost_mask = (27'd1 << shamt) - 27'd1;
            man_sh    = (man_in >> shamt) | {26'd0, |(man_in & lost_mask)};
         end
      end
      // nearest even
      inc = man_sh[2] & (man_sh[3] | man_sh[1] | man_sh[0]);
      sum = {1'b0, man_sh[26:3]} + {24'd0, inc};
      if (exp_n == 10'd0) begin
         exp_out = {9'd0, sum[23]};
      end else begin
         exp_out = exp_n + {9'd0, sum[24]};
      end
      if (exp_out >= 10'd255) begin
         res = {sgn, 8'hFF, 23'd0};
      end else begin
         res = {sgn, exp_out[7:0], sum[22:0]};
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/matmul_bias_fp32.sv =====
// ----------------------------------------------------------------------------
// matmul_bias_fp32
// Single-precision matrix multiply-add with optional bias: loads A, B and
// C element by element, then streams every result element in row order.
// ----------------------------------------------------------------------------
//
//  channel  ports                                        direction
//  req      req_valid/ready, kind, row, col, value       in
//  rsp      rsp_valid/ready, out_row, out_col,           out
//           out_value, last
//  csr      csr_write_en, csr_index, csr_wdata           in, write only
//
// A load item reaches memory through a four-entry queue. A start item
// yields rows*cols results; each inner step passes through a memory read,
// the multiplier and the adder, and takes longer when subnormal operands
// or cancellation need extra normalizing shifts. The multiplier and adder
// are single shared units. Reset empties the queue, returns the sequencers
// to idle and sets the dimension registers to eight with bias off; memory
// is not cleared. A stalled result holds the back end, the queue keeps
// taking items until its four entries are full.
// ----------------------------------------------------------------------------
module matmul_bias_fp32 #(
   parameter int MAX_DIM = mba_pkg::MBA_MAX_DIM
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_row,
   input  logic [2:0]  req_col,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_row,
   output logic [2:0]  rsp_out_col,
   output logic [31:0] rsp_out_value,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import mba_pkg::*;

   localparam int AW = $clog2(MAX_DIM * MAX_DIM);

   logic [3:0] row_count_ff, row_count_in;
   logic [3:0] col_count_ff, col_count_in;
   logic [3:0] inner_count_ff, inner_count_in;
   logic       bias_enable_ff, bias_enable_in;
   cfg_type    cfg;

   logic          q_valid, q_ready;
   kind_type      q_kind;
   logic [AW-1:0] q_addr;
   logic [31:0]   q_value;

   function automatic logic [3:0] clamp_dim(input logic [3:0] v);
      logic [3:0] res;
      res = v;
      if (v == 4'd0) begin
         res = 4'd1;
      end else if (v > 4'(MAX_DIM)) begin
         res = 4'(MAX_DIM);
      end
      return res;
   endfunction

   // register writes
   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      inner_count_in = inner_count_ff;
      bias_enable_in = bias_enable_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:   row_count_in   = csr_wdata;
            CSR_COL_COUNT:   col_count_in   = csr_wdata;
            CSR_INNER_COUNT: inner_count_in = csr_wdata;
            CSR_BIAS_ENABLE: bias_enable_in = csr_wdata[0];
            default: begin
               row_count_in = row_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= 4'd8;
         col_count_ff   <= 4'd8;
         inner_count_ff <= 4'd8;
         bias_enable_ff <= 1'b0;
      end else begin
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         inner_count_ff <= inner_count_in;
         bias_enable_ff <= bias_enable_in;
      end
   end

   // dimensions in range for the back end
   assign cfg.rows  = clamp_dim(row_count_ff);
   assign cfg.cols  = clamp_dim(col_count_ff);
   assign cfg.inner = clamp_dim(inner_count_ff);
   assign cfg.bias  = bias_enable_ff;

   mba_front #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_value (req_value),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_kind    (q_kind),
      .q_addr    (q_addr),
      .q_value   (q_value)
   );

   mba_back #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_kind        (q_kind),
      .q_addr        (q_addr),
      .q_value       (q_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   // the run ends on the bottom right element
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (((4'(rsp_out_row) + 4'd1) == cfg.rows) && ((4'(rsp_out_col) + 4'd1) == cfg.cols)))
      else $error("last item is not the final element");

   // results stay inside the configured shape
   a_in_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((4'(rsp_out_row) < cfg.rows) && (4'(rsp_out_col) < cfg.cols)))
      else $error("result index outside the matrix");

   // the back end takes no queued item while a result is pending
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !q_ready)
      else $error("queue popped while a result waits");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== hw/rtl/mba_fmul.sv =====
// ----------------------------------------------------------------------------
// mba_fmul
// Multi-cycle binary32 multiplier: one product step, then normalizing
// steps of eight or one bit, then round and pack.
// ----------------------------------------------------------------------------
module mba_fmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic        done,
   output logic [31:0] result
);
   import mba_pkg::*;

   typedef enum logic [2:0] {
      MS_IDLE = 3'b001,
      MS_CALC = 3'b010,
      MS_NORM = 3'b100
   } mul_state_type;

   mul_state_type      state_ff, state_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic [47:0]        prod_ff, prod_in;
   logic signed [11:0] exp_ff, exp_in;
   logic               sign_ff, sign_in;
   logic [31:0]        res_ff, res_in;
   logic               done_ff, done_in;

   logic [7:0]  ea, eb, ea_adj, eb_adj;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0] siga, sigb;

   // operand decode
   assign ea     = a_ff[30:23];
   assign eb     = b_ff[30:23];
   assign a_nan  = (ea == 8'hFF) && (a_ff[22:0] != 23'd0);
   assign b_nan  = (eb == 8'hFF) && (b_ff[22:0] != 23'd0);
   assign a_inf  = (ea == 8'hFF) && (a_ff[22:0] == 23'd0);
   assign b_inf  = (eb == 8'hFF) && (b_ff[22:0] == 23'd0);
   assign a_zero = (a_ff[30:0] == 31'd0);
   assign b_zero = (b_ff[30:0] == 31'd0);
   assign ea_adj = (ea == 8'd0) ? 8'd1 : ea;
   assign eb_adj = (eb == 8'd0) ? 8'd1 : eb;
   assign siga   = {(ea != 8'd0), a_ff[22:0]};
   assign sigb   = {(eb != 8'd0), b_ff[22:0]};

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      prod_in  = prod_ff;
      exp_in   = exp_ff;
      sign_in  = sign_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         MS_IDLE: begin
            if (start) begin
               a_in     = op_a;
               b_in     = op_b;
               state_in = MS_CALC;
            end
         end
         MS_CALC: begin
            sign_in = a_ff[31] ^ b_ff[31];
            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
               res_in   = FP_QNAN;
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end else if (a_inf || b_inf) begin
               res_in   = {a_ff[31] ^ b_ff[31], 8'hFF, 23'd0};
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end else if (a_zero || b_zero) begin
               res_in   = {a_ff[31] ^ b_ff[31], 31'd0};
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end else begin
               prod_in  = 48'(siga) * 48'(sigb);
               exp_in   = $signed({4'd0, ea_adj}) + $signed({4'd0, eb_adj}) - 12'sd126;
               state_in = MS_NORM;
            end
         end
         MS_NORM: begin
            if (prod_ff[47]) begin
               res_in   = fp_round_pack(sign_ff, exp_ff,
                                        {prod_ff[47:22], |prod_ff[21:0]});
               done_in  = 1'b1;
               state_in = MS_IDLE;
            end else if (prod_ff[47:40] == 8'd0) begin
               prod_in = prod_ff << 8;
               exp_in  = exp_ff - 12'sd8;
            end else begin
               prod_in = prod_ff << 1;
               exp_in  = exp_ff - 12'sd1;
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      exp_ff  <= exp_in;
      sign_ff <= sign_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== hw/rtl/mba_fadd.sv =====
// ----------------------------------------------------------------------------
// mba_fadd
// Multi-cycle binary32 adder: align and add in one step, normalize in
// steps of eight or one bit, then round and pack.
// ----------------------------------------------------------------------------
module mba_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic        done,
   output logic [31:0] result
);
   import mba_pkg::*;

   typedef enum logic [2:0] {
      AS_IDLE = 3'b001,
      AS_CALC = 3'b010,
      AS_NORM = 3'b100
   } add_state_type;

   add_state_type      state_ff, state_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic [27:0]        sum_ff, sum_in;
   logic signed [11:0] exp_ff, exp_in;
   logic               sign_ff, sign_in;
   logic [31:0]        res_ff, res_in;
   logic               done_ff, done_in;

   logic        a_nan, b_nan, a_inf, b_inf;
   logic        swap, eff_sub;
   logic [31:0] big, sml;
   logic [7:0]  e_big, e_sml, dexp;
   logic [26:0] x_full, y_full, y_sh;
   logic [27:0] sum_raw;
   logic signed [11:0] pk_exp;
   logic [26:0] pk_man;

   // operand decode
   assign a_nan = (a_ff[30:23] == 8'hFF) && (a_ff[22:0] != 23'd0);
   assign b_nan = (b_ff[30:23] == 8'hFF) && (b_ff[22:0] != 23'd0);
   assign a_inf = (a_ff[30:23] == 8'hFF) && (a_ff[22:0] == 23'd0);
   assign b_inf = (b_ff[30:23] == 8'hFF) && (b_ff[22:0] == 23'd0);

   // align the smaller magnitude and add or subtract
   always_comb begin
      swap    = (b_ff[30:0] > a_ff[30:0]);
      big     = swap ? b_ff : a_ff;
      sml     = swap ? a_ff : b_ff;
      e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      dexp    = e_big - e_sml;
      x_full  = {(big[30:23] != 8'd0), big[22:0], 3'b000};
      y_full  = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
      if (dexp >= 8'd27) begin
         y_sh = {26'd0, |y_full};
      end else begin
         y_sh = (y_full >> dexp[4:0])
              | {26'd0, |(y_full & ((27'd1 << dexp[4:0]) - 27'd1))};
      end
      eff_sub = big[31] ^ sml[31];
      if (eff_sub) begin
         sum_raw = {1'b0, x_full} - {1'b0, y_sh};
      end else begin
         sum_raw = {1'b0, x_full} + {1'b0, y_sh};
      end
   end

   // pick the rounding input once normalized
   always_comb begin
      if (sum_ff[27]) begin
         pk_exp = exp_ff + 12'sd1;
         pk_man = {sum_ff[27:2], |sum_ff[1:0]};
      end else begin
         pk_exp = exp_ff;
         pk_man = sum_ff[26:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      sum_in   = sum_ff;
      exp_in   = exp_ff;
      sign_in  = sign_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         AS_IDLE: begin
            if (start) begin
               a_in     = op_a;
               b_in     = op_b;
               state_in = AS_CALC;
            end
         end
         AS_CALC: begin
            if (a_nan || b_nan || (a_inf && b_inf && (a_ff[31] != b_ff[31]))) begin
               res_in   = FP_QNAN;
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else if (a_inf) begin
               res_in   = {a_ff[31], 8'hFF, 23'd0};
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else if (b_inf) begin
               res_in   = {b_ff[31], 8'hFF, 23'd0};
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else if (sum_raw == 28'd0) begin
               // exact zero: minus only when both addends are minus zero
               res_in   = eff_sub ? 32'd0 : {big[31], 31'd0};
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else begin
               sum_in   = sum_raw;
               exp_in   = $signed({4'd0, e_big});
               sign_in  = big[31];
               state_in = AS_NORM;
            end
         end
         AS_NORM: begin
            if (sum_ff[27] || sum_ff[26]) begin
               res_in   = fp_round_pack(sign_ff, pk_exp, pk_man);
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else if (sum_ff[26:19] == 8'd0) begin
               sum_in = sum_ff << 8;
               exp_in = exp_ff - 12'sd8;
            end else begin
               sum_in = sum_ff << 1;
               exp_in = exp_ff - 12'sd1;
            end
         end
         default: begin
            state_in = AS_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      sum_ff  <= sum_in;
      exp_ff  <= exp_in;
      sign_ff <= sign_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== hw/rtl/mba_front.sv =====
// ----------------------------------------------------------------------------
// mba_front
// Accepts input items, drops loads with an index outside the matrix,
// forms the element address and queues the item for the back end.
// ----------------------------------------------------------------------------
module mba_front #(
   parameter int MAX_DIM = mba_pkg::MBA_MAX_DIM,
   parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [2:0]          req_row,
   input  logic [2:0]          req_col,
   input  logic [31:0]         req_value,
   output logic                q_valid,
   input  logic                q_ready,
   output mba_pkg::kind_type   q_kind,
   output logic [AW-1:0]       q_addr,
   output logic [31:0]         q_value
);
   import mba_pkg::*;

   localparam int DEPTH = MBA_QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   kind_type      kind_ff  [DEPTH];
   logic [AW-1:0] addr_ff  [DEPTH];
   logic [31:0]   value_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   kind_type      kind;
   logic          in_range, keep, push, pop;
   logic [AW-1:0] addr;

   // classify the incoming item
   assign kind     = kind_type'(req_kind);
   assign in_range = (4'(req_row) < 4'(MAX_DIM)) && (4'(req_col) < 4'(MAX_DIM));
   assign keep     = (kind == KIND_START) || in_range;
   assign addr     = AW'(req_row) * AW'(MAX_DIM) + AW'(req_col);

   // queue handshake
   assign req_ready = (count_ff != (PW + 1)'(DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_ready;

   assign wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW + 1)'(1);
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff]  <= kind;
         addr_ff[wr_ptr_ff]  <= addr;
         value_ff[wr_ptr_ff] <= req_value;
      end
   end

   assign q_kind  = kind_ff[rd_ptr_ff];
   assign q_addr  = addr_ff[rd_ptr_ff];
   assign q_value = value_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/mba_back.sv =====
// ----------------------------------------------------------------------------
// mba_back
// Holds the A, B and bias memories, stores load items and runs the
// multiply-accumulate sequence for a start item, one result at a time.
// ----------------------------------------------------------------------------
module mba_back #(
   parameter int MAX_DIM = mba_pkg::MBA_MAX_DIM,
   parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
   input  logic                clock,
   input  logic                reset,
   input  mba_pkg::cfg_type    cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  mba_pkg::kind_type   q_kind,
   input  logic [AW-1:0]       q_addr,
   input  logic [31:0]         q_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_out_row,
   output logic [2:0]          rsp_out_col,
   output logic [31:0]         rsp_out_value,
   output logic                rsp_last
);
   import mba_pkg::*;

   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int IW        = $clog2(MAX_DIM);

   typedef enum logic [6:0] {
      BS_IDLE     = 7'b0000001,
      BS_READ     = 7'b0000010,
      BS_MUL_GO   = 7'b0000100,
      BS_MUL_WAIT = 7'b0001000,
      BS_ADD_GO   = 7'b0010000,
      BS_ADD_WAIT = 7'b0100000,
      BS_OUT      = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  r_ff, r_in;
   logic [IW-1:0]  c_ff, c_in;
   logic [IW-1:0]  l_ff, l_in;
   logic           bias_phase_ff, bias_phase_in;
   logic [31:0]    acc_ff, acc_in;
   logic [31:0]    prod_ff, prod_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_row_ff, rsp_row_in;
   logic [2:0]     rsp_col_ff, rsp_col_in;
   logic [31:0]    rsp_value_ff, rsp_value_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [31:0] mem_a [MEM_DEPTH];
   logic [31:0] mem_b [MEM_DEPTH];
   logic [31:0] mem_c [MEM_DEPTH];
   logic [31:0] rd_a_ff, rd_b_ff, rd_c_ff;

   logic [AW-1:0] addr_a, addr_b, addr_c;
   logic          last_l, last_c, last_r;
   logic          pop, rd_en;
   logic          mul_start, mul_done, add_start, add_done;
   logic [31:0]   mul_result, add_result, add_rhs;

   // element addresses of the current step
   assign addr_a = AW'(r_ff) * AW'(MAX_DIM) + AW'(l_ff);
   assign addr_b = AW'(l_ff) * AW'(MAX_DIM) + AW'(c_ff);
   assign addr_c = AW'(r_ff) * AW'(MAX_DIM) + AW'(c_ff);

   assign last_l = ((4'(l_ff) + 4'd1) == cfg.inner);
   assign last_c = ((4'(c_ff) + 4'd1) == cfg.cols);
   assign last_r = ((4'(r_ff) + 4'd1) == cfg.rows);

   assign q_ready   = (state_ff == BS_IDLE);
   assign pop       = q_valid && q_ready;
   assign rd_en     = (state_ff == BS_READ);
   assign mul_start = (state_ff == BS_MUL_GO);
   assign add_start = (state_ff == BS_ADD_GO);
   assign add_rhs   = bias_phase_ff ? rd_c_ff : prod_ff;

   // arithmetic units
   mba_fmul u_fmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (rd_a_ff),
      .op_b   (rd_b_ff),
      .done   (mul_done),
      .result (mul_result)
   );

   mba_fadd u_fadd (
      .clock  (clock),
      .reset  (reset),
      .start  (add_start),
      .op_a   (acc_ff),
      .op_b   (add_rhs),
      .done   (add_done),
      .result (add_result)
   );

   // matrix memories
   always_ff @(posedge clock) begin
      if (pop && (q_kind == KIND_A)) begin
         mem_a[q_addr] <= q_value;
      end
      if (pop && (q_kind == KIND_B)) begin
         mem_b[q_addr] <= q_value;
      end
      if (pop && (q_kind == KIND_C)) begin
         mem_c[q_addr] <= q_value;
      end
      if (rd_en) begin
         rd_a_ff <= mem_a[addr_a];
         rd_b_ff <= mem_b[addr_b];
         rd_c_ff <= mem_c[addr_c];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      l_in          = l_ff;
      bias_phase_in = bias_phase_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         BS_IDLE: begin
            if (pop && (q_kind == KIND_START)) begin
               r_in          = '0;
               c_in          = '0;
               l_in          = '0;
               bias_phase_in = 1'b0;
               acc_in        = 32'd0;
               state_in      = BS_READ;
            end
         end
         BS_READ: begin
            state_in = BS_MUL_GO;
         end
         BS_MUL_GO: begin
            state_in = BS_MUL_WAIT;
         end
         BS_MUL_WAIT: begin
            if (mul_done) begin
               prod_in  = mul_result;
               state_in = BS_ADD_GO;
            end
         end
         BS_ADD_GO: begin
            state_in = BS_ADD_WAIT;
         end
         BS_ADD_WAIT: begin
            if (add_done) begin
               acc_in = add_result;
               if (bias_phase_ff || (last_l && !cfg.bias)) begin
                  // element finished, hand it to the output register
                  rsp_valid_in = 1'b1;
                  rsp_row_in   = 3'(r_ff);
                  rsp_col_in   = 3'(c_ff);
                  rsp_value_in = add_result;
                  rsp_last_in  = last_r && last_c;
                  state_in     = BS_OUT;
               end else if (last_l) begin
                  bias_phase_in = 1'b1;
                  state_in      = BS_ADD_GO;
               end else begin
                  l_in     = l_ff + IW'(1);
                  state_in = BS_READ;
               end
            end
         end
         BS_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = BS_IDLE;
               end else begin
                  if (last_c) begin
                     c_in = '0;
                     r_in = r_ff + IW'(1);
                  end else begin
                     c_in = c_ff + IW'(1);
                  end
                  l_in          = '0;
                  bias_phase_in = 1'b0;
                  acc_in        = 32'd0;
                  state_in      = BS_READ;
               end
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      r_ff          <= r_in;
      c_ff          <= c_in;
      l_ff          <= l_in;
      bias_phase_ff <= bias_phase_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
